FILE: rtl/prlm_pkg.sv
// prlm_pkg: shared types, character codes and reset values for the poll/response link monitor
// used by prlm_num_parse and poll_response_link_monitor_core; no dependencies
package prlm_pkg;

   localparam int MAX_FRAME = 64;
   localparam int RX_POS_W  = $clog2(MAX_FRAME + 1);

   localparam logic [15:0] SEND_INTERVAL_RST   = 16'd20;
   localparam logic [31:0] REINIT_INTERVAL_RST = 32'd300000;
   localparam logic [7:0]  FAIL_LIMIT_RST      = 8'd50;

   localparam logic [1:0] CSR_SEND_INTERVAL   = 2'd0;
   localparam logic [1:0] CSR_REINIT_INTERVAL = 2'd1;
   localparam logic [1:0] CSR_FAIL_LIMIT      = 2'd2;

   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_U     = 8'h55;
   localparam logic [7:0] CH_H     = 8'h48;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_THREE = 8'h33;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;

   localparam logic [31:0] MAG_CAP = 32'h8000_0000;
   localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WAIT  = 3'b010,
      ST_CHECK = 3'b100
   } ctrl_state_type;

   typedef enum logic [1:0] {
      CMD_NONE   = 2'd0,
      CMD_LINK   = 2'd1,
      CMD_SELECT = 2'd2,
      CMD_PUMP   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic       clear;
      logic       feed;
      logic [7:0] data;
   } parse_ctl_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] first;
      logic [31:0] second;
   } parse_stat_type;

endpackage

FILE: rtl/prlm_num_parse.sv
// prlm_num_parse: byte-wise parser for two signed decimals separated by a comma
// depends on prlm_pkg
module prlm_num_parse
   import prlm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  parse_ctl_type  ctl,
   output parse_stat_type stat
);

   typedef enum logic [7:0] {
      PH_LEAD1  = 8'b0000_0001,
      PH_SIGN1  = 8'b0000_0010,
      PH_DIG1   = 8'b0000_0100,
      PH_LEAD2  = 8'b0000_1000,
      PH_SIGN2  = 8'b0001_0000,
      PH_DIG2   = 8'b0010_0000,
      PH_FAIL   = 8'b0100_0000,
      PH_DONE   = 8'b1000_0000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] mag1_ff, mag1_in, mag2_ff, mag2_in;
   logic        neg1_ff, neg1_in, neg2_ff, neg2_in;

   logic        is_dig, is_sgn, is_spc, is_neg;
   logic [3:0]  digit;
   logic [31:0] acc1, acc2;

   function automatic logic [31:0] accum(input logic [31:0] m, input logic [3:0] d);
      logic [35:0] t;
      t = ({4'd0, m} << 3) + ({4'd0, m} << 1) + {32'd0, d};
      return (t > {4'd0, MAG_CAP}) ? MAG_CAP : t[31:0];
   endfunction

   function automatic logic [31:0] to_bits(input logic [31:0] m, input logic neg);
      if (neg) begin
         return (m >= MAG_CAP) ? MAG_CAP : (32'd0 - m);
      end
      return (m > POS_MAX) ? POS_MAX : m;
   endfunction

   assign is_dig = (ctl.data >= CH_ZERO) && (ctl.data <= CH_NINE);
   assign is_neg = (ctl.data == CH_MINUS);
   assign is_sgn = (ctl.data == CH_PLUS) || is_neg;
   assign is_spc = (ctl.data == CH_SPACE) || ((ctl.data >= CH_TAB) && (ctl.data <= CH_CR));
   assign digit  = ctl.data[3:0];
   assign acc1   = accum(mag1_ff, digit);
   assign acc2   = accum(mag2_ff, digit);

   always_comb begin
      phase_in = phase_ff;
      mag1_in  = mag1_ff;
      mag2_in  = mag2_ff;
      neg1_in  = neg1_ff;
      neg2_in  = neg2_ff;
      if (ctl.clear) begin
         phase_in = PH_LEAD1;
         mag1_in  = '0;
         mag2_in  = '0;
         neg1_in  = 1'b0;
         neg2_in  = 1'b0;
      end else if (ctl.feed) begin
         case (phase_ff)
            PH_LEAD1, PH_SIGN1: begin
               if (phase_ff == PH_LEAD1 && is_spc) begin
                  phase_in = PH_LEAD1;
               end else if (phase_ff == PH_LEAD1 && is_sgn) begin
                  neg1_in  = is_neg;
                  phase_in = PH_SIGN1;
               end else if (is_dig) begin
                  mag1_in  = acc1;
                  phase_in = PH_DIG1;
               end else begin
                  phase_in = PH_FAIL;
               end
            end
            PH_DIG1: begin
               if (is_dig) begin
                  mag1_in = acc1;
               end else begin
                  phase_in = (ctl.data == CH_COMMA) ? PH_LEAD2 : PH_FAIL;
               end
            end
            PH_LEAD2, PH_SIGN2: begin
               if (phase_ff == PH_LEAD2 && is_spc) begin
                  phase_in = PH_LEAD2;
               end else if (phase_ff == PH_LEAD2 && is_sgn) begin
                  neg2_in  = is_neg;
                  phase_in = PH_SIGN2;
               end else if (is_dig) begin
                  mag2_in  = acc2;
                  phase_in = PH_DIG2;
               end else begin
                  phase_in = PH_FAIL;
               end
            end
            PH_DIG2: begin
               if (is_dig) begin
                  mag2_in = acc2;
               end else begin
                  phase_in = PH_DONE;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD1;
         mag1_ff  <= '0;
         mag2_ff  <= '0;
         neg1_ff  <= 1'b0;
         neg2_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         mag1_ff  <= mag1_in;
         mag2_ff  <= mag2_in;
         neg1_ff  <= neg1_in;
         neg2_ff  <= neg2_in;
      end
   end

   assign stat.valid  = (phase_ff == PH_DIG2) || (phase_ff == PH_DONE);
   assign stat.first  = to_bits(mag1_ff, neg1_ff);
   assign stat.second = to_bits(mag2_ff, neg2_ff);

endmodule

FILE: rtl/poll_response_link_monitor_core.sv
// poll_response_link_monitor_core: polls a serial peripheral and tracks its link status
// depends on prlm_pkg and prlm_num_parse
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  tuser func, tdata rx_byte/pump_active/handle_selected
//  rsp      out  rsp_tvalid/rsp_tready  tdata status, command and parsed values
//  csr      in   csr_wen                csr_addr, csr_wdata
//
//  one request per cycle sustained while rsp_tready is high; each response passes
//  through the input register, then the result register, which drives rsp_tvalid/rsp_tdata
//  reset clears all control and status state and loads the register defaults
//  a stalled response holds in the result register while the input register still
//  takes one more request; req_tready drops only when both are full
module poll_response_link_monitor_core
   import prlm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // rx_byte[7:0], pump_active[8], handle_selected[9], zero
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // send_cmd[1:0], uart_reinit[2], check_done[3], link_up[4], link_number[6:5],
   // parse_ok[7], gyro_value[39:8], press_value[71:40]
   output logic [71:0] rsp_tdata,
   input  logic        csr_wen,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   logic [15:0] send_int_ff;
   logic [31:0] reinit_int_ff;
   logic [7:0]  fail_lim_ff;

   logic        s1_valid_ff, s1_valid_in;
   logic        s1_func_ff;
   logic [7:0]  s1_byte_ff;
   logic        s1_pump_ff, s1_sel_ff;
   logic        s1_fire;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [71:0] rsp_data_ff;

   logic [31:0]    tick_ff, tick_in;
   logic [31:0]    last_send_ff, last_send_in;
   logic [31:0]    last_reinit_ff, last_reinit_in;
   ctrl_state_type state_ff, state_in;
   cmd_type        last_cmd_ff, last_cmd_in;
   logic [7:0]     fail_ff, fail_in;
   logic           pend_ff, pend_in;
   logic           link_up_ff, link_up_in;
   logic [1:0]     link_num_ff, link_num_in;
   logic [7:0]     hdr_ff [4];
   logic [RX_POS_W-1:0] rx_pos_ff, rx_pos_in;
   logic [31:0]    gyro_ff, gyro_in, press_ff, press_in;

   parse_ctl_type  pctl;
   parse_stat_type pstat;

   logic [31:0] now, since_send, since_reinit;
   logic        send_due, reinit_due, hdr_wr, hdr_ok, reply_ok;
   logic [7:0]  want, fail_inc;
   cmd_type     cmd;
   logic        do_reinit, done, pok;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         send_int_ff   <= SEND_INTERVAL_RST;
         reinit_int_ff <= REINIT_INTERVAL_RST;
         fail_lim_ff   <= FAIL_LIMIT_RST;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_SEND_INTERVAL:   send_int_ff   <= csr_wdata[15:0];
            CSR_REINIT_INTERVAL: reinit_int_ff <= csr_wdata;
            CSR_FAIL_LIMIT:      fail_lim_ff   <= csr_wdata[7:0];
            default:             fail_lim_ff   <= fail_lim_ff;
         endcase
      end
   end

   // handshake
   assign s1_fire     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || s1_fire;
   assign s1_valid_in = (req_tvalid && req_tready) ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_func_ff <= req_tuser;
         s1_byte_ff <= req_tdata[7:0];
         s1_pump_ff <= req_tdata[8];
         s1_sel_ff  <= req_tdata[9];
      end
   end

   // timing
   assign now          = tick_ff + 32'd1;
   assign since_send   = now - last_send_ff;
   assign since_reinit = now - last_reinit_ff;
   assign hdr_wr       = s1_fire && s1_func_ff && (state_ff == ST_WAIT)
                         && (rx_pos_ff < RX_POS_W'(MAX_FRAME)) && (rx_pos_ff < RX_POS_W'(4));
   assign hdr_ok       = (hdr_ff[0] == CH_A) && (hdr_ff[1] == CH_T);
   assign want         = (last_cmd_ff == CMD_PUMP) ? CH_P
                         : (last_cmd_ff == CMD_SELECT) ? CH_U : CH_H;
   assign reply_ok     = hdr_ok && (hdr_ff[2] == want);
   assign fail_inc     = fail_ff + 8'd1;

   always_comb begin
      tick_in        = tick_ff;
      last_send_in   = last_send_ff;
      last_reinit_in = last_reinit_ff;
      state_in       = state_ff;
      last_cmd_in    = last_cmd_ff;
      fail_in        = fail_ff;
      pend_in        = pend_ff;
      link_up_in     = link_up_ff;
      link_num_in    = link_num_ff;
      rx_pos_in      = rx_pos_ff;
      gyro_in        = gyro_ff;
      press_in       = press_ff;
      pctl.clear     = 1'b0;
      pctl.feed      = 1'b0;
      pctl.data      = s1_byte_ff;
      cmd            = CMD_NONE;
      do_reinit      = 1'b0;
      done           = 1'b0;
      pok            = 1'b0;
      reinit_due     = 1'b0;
      send_due       = 1'b0;
      if (s1_fire && s1_func_ff) begin
         if (state_ff == ST_WAIT && rx_pos_ff < RX_POS_W'(MAX_FRAME)) begin
            pctl.feed = (rx_pos_ff >= RX_POS_W'(4));
            rx_pos_in = rx_pos_ff + RX_POS_W'(1);
         end
      end else if (s1_fire) begin
         tick_in    = now;
         reinit_due = (since_reinit >= reinit_int_ff) && !pend_ff;
         if (reinit_due) begin
            pend_in        = 1'b1;
            last_reinit_in = now;
         end
         send_due = (state_ff == ST_IDLE) && (since_send >= {16'd0, send_int_ff});
         if (send_due) begin
            last_send_in = now;
            if (pend_ff || reinit_due) begin
               do_reinit = 1'b1;
            end else begin
               cmd = (s1_pump_ff && s1_sel_ff) ? CMD_PUMP
                     : s1_sel_ff ? CMD_SELECT : CMD_LINK;
               last_cmd_in = cmd;
            end
         end
         if (do_reinit) begin
            pctl.clear = 1'b1;
            rx_pos_in  = '0;
            pend_in    = 1'b0;
            fail_in    = '0;
         end else if (cmd != CMD_NONE) begin
            pctl.clear = 1'b1;
            rx_pos_in  = '0;
            state_in   = ST_WAIT;
         end else if (state_ff == ST_WAIT) begin
            if (rx_pos_ff != '0 || since_send >= {17'd0, send_int_ff[15:1]}) begin
               state_in = ST_CHECK;
            end
         end else if (state_ff == ST_CHECK) begin
            done = 1'b1;
            if (hdr_ok && pstat.valid) begin
               gyro_in  = pstat.first;
               press_in = pstat.second;
               pok      = 1'b1;
            end
            if (reply_ok) begin
               fail_in     = '0;
               link_up_in  = 1'b1;
               link_num_in = (hdr_ff[3] >= CH_ONE && hdr_ff[3] <= CH_THREE)
                             ? hdr_ff[3][1:0] : 2'd0;
            end else if (fail_inc > fail_lim_ff) begin
               fail_in     = '0;
               link_up_in  = 1'b0;
               link_num_in = 2'd0;
            end else begin
               fail_in = fail_inc;
            end
            state_in = ST_IDLE;
         end else begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff        <= '0;
         last_send_ff   <= '0;
         last_reinit_ff <= '0;
         state_ff       <= ST_IDLE;
         last_cmd_ff    <= CMD_LINK;
         fail_ff        <= '0;
         pend_ff        <= 1'b0;
         link_up_ff     <= 1'b0;
         link_num_ff    <= 2'd0;
         rx_pos_ff      <= '0;
         gyro_ff        <= '0;
         press_ff       <= '0;
      end else begin
         tick_ff        <= tick_in;
         last_send_ff   <= last_send_in;
         last_reinit_ff <= last_reinit_in;
         state_ff       <= state_in;
         last_cmd_ff    <= last_cmd_in;
         fail_ff        <= fail_in;
         pend_ff        <= pend_in;
         link_up_ff     <= link_up_in;
         link_num_ff    <= link_num_in;
         rx_pos_ff      <= rx_pos_in;
         gyro_ff        <= gyro_in;
         press_ff       <= press_in;
      end
   end

   // reply header
   always_ff @(posedge clock) begin
      if (reset || pctl.clear) begin
         for (int i = 0; i < 4; i++) begin
            hdr_ff[i] <= '0;
         end
      end else if (hdr_wr) begin
         hdr_ff[rx_pos_ff[1:0]] <= s1_byte_ff;
      end
   end

   prlm_num_parse u_parse (
      .clock (clock),
      .reset (reset),
      .ctl   (pctl),
      .stat  (pstat)
   );

   // result register
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_data_ff <= {press_in, gyro_in, pok, link_num_in, link_up_in, done,
                         do_reinit, cmd};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_cmd_enters_wait: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && cmd != CMD_NONE) |=> (state_ff == ST_WAIT))
      else $error("command issued without entering wait");

   a_reinit_no_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[2] && rsp_tdata[1:0] != CMD_NONE))
      else $error("reinit and command on same tick");

   a_parse_needs_check: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[7] || rsp_tdata[3]))
      else $error("parse_ok without check");

   a_num_needs_link: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[6:5] == 2'd0 || rsp_tdata[4]))
      else $error("link number while link down");

endmodule
